FILE: hw/rtl/rlt_pkg.sv
// Package for the region lock table: constants, status codes and controller states.
package rlt_pkg;

  // Default number of lock regions.
  localparam int REGION_COUNT_DEF = 256;
  // Bytes per region (a power of two) and the matching shift.
  localparam int REGION_BYTES    = 64;
  localparam int REGION_SHIFT    = $clog2(REGION_BYTES);
  // Requester identities and the holder field width.
  localparam int MAX_REQUESTERS  = 16;
  localparam int REQ_W           = $clog2(MAX_REQUESTERS);
  // Hold counter width and its saturation value.
  localparam int COUNT_W         = 8;
  localparam logic [COUNT_W-1:0] HOLD_MAX = '1;
  // Field widths of the request and configuration ports.
  localparam int OFFSET_W        = 14;
  localparam int LENGTH_W        = 15;
  localparam int CFG_W           = 9;
  localparam logic [CFG_W-1:0] REGIONS_RESET = 9'd256;
  localparam int REGION_OUT_W    = 8;
  localparam int REGION_OUT_MAX  = 255;

  // Request commands.
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_DONE     = 3'd0,
    STATUS_CONFLICT = 3'd1,
    STATUS_RANGE    = 3'd2,
    STATUS_OVERFLOW = 3'd3,
    STATUS_UNHELD   = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_UPDATE
  } state_t;

endpackage

FILE: hw/rtl/rlt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/region_lock_table_unit.sv
// Top level of the region lock table: request controller over the count and holder memories.
// A request that has zero length or reaches past the regions in use gets its result in the
// cycle after it is accepted. Any other request walks its N covered regions twice through
// the single read port of the count memory, once to check and once to update, with busy
// high throughout, and no new request is accepted until it is done; a refused request
// ends after the check walk. After reset the count memory is cleared one entry a cycle
// with busy high; configuration writes are taken during that time. Each result is
// shown for one cycle with out_valid and cannot be held off by the receiver.
module region_lock_table_unit
  import rlt_pkg::*;
#(
  parameter int REGION_COUNT = REGION_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_command,
  input  logic [OFFSET_W-1:0]     in_start_offset,
  input  logic [LENGTH_W-1:0]     in_range_length,
  input  logic [REQ_W-1:0]        in_requester,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [REGION_OUT_W-1:0] out_conflict_region,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int AW    = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int LIM_W = $clog2(REGION_COUNT + 1);
  localparam int CMP_W = (LIM_W > LENGTH_W + 1) ? LIM_W : LENGTH_W + 1;

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        regions_r;
  logic                    cmd_r, cmd_nxt;
  logic [REQ_W-1:0]        who_r, who_nxt;
  logic [AW-1:0]           first_r, first_nxt;
  logic [AW-1:0]           last_r, last_nxt;
  logic [AW-1:0]           dptr_r, dptr_nxt;
  logic                    a_found_r, a_found_nxt;
  logic [AW-1:0]           a_idx_r, a_idx_nxt;
  logic                    b_found_r, b_found_nxt;
  logic [AW-1:0]           b_idx_r, b_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [REGION_OUT_W-1:0] out_region_r, out_region_nxt;

  // Memory ports.
  logic                    cnt_we;
  logic [COUNT_W-1:0]      cnt_wdata;
  logic [COUNT_W-1:0]      cnt_rdata;
  logic                    hold_we;
  logic [REQ_W-1:0]        hold_rdata;
  logic [AW-1:0]           rd_addr;

  // Request decode.
  logic [CMP_W-1:0]        end_byte;
  logic [CMP_W-1:0]        first_w;
  logic [CMP_W-1:0]        last_w;
  logic [CMP_W-1:0]        limit_w;
  logic [CMP_W-1:0]        bad_w;
  logic                    len_zero;
  logic                    out_of_range;

  // Per-region check results.
  logic                    hit_a;
  logic                    hit_b;
  logic                    a_any;
  logic                    b_any;
  logic [AW-1:0]           a_sel;
  logic [AW-1:0]           b_sel;
  logic                    last_step;
  logic [AW-1:0]           dptr_inc;

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_conflict_region = out_region_r;

  // Range of the incoming request, in region units.
  always_comb begin
    end_byte = CMP_W'(in_start_offset) + CMP_W'(in_range_length) - CMP_W'(1);
    first_w  = CMP_W'(in_start_offset) >> REGION_SHIFT;
    last_w   = end_byte >> REGION_SHIFT;
    if (CMP_W'(regions_r) > CMP_W'(REGION_COUNT)) begin
      limit_w = CMP_W'(REGION_COUNT);
    end else begin
      limit_w = CMP_W'(regions_r);
    end
    len_zero     = (in_range_length == '0);
    out_of_range = (last_w >= limit_w);
    bad_w        = (first_w > limit_w) ? first_w : limit_w;
    if (bad_w > CMP_W'(REGION_OUT_MAX)) begin
      bad_w = CMP_W'(REGION_OUT_MAX);
    end
  end

  // Evaluation of the entry whose read data is arriving.
  always_comb begin
    if (cmd_r == CMD_ACQUIRE) begin
      hit_a = (cnt_rdata != '0) && (hold_rdata != who_r);
      hit_b = (cnt_rdata == HOLD_MAX);
    end else begin
      hit_a = (cnt_rdata == '0);
      hit_b = 1'b0;
    end
    a_any     = a_found_r | hit_a;
    b_any     = b_found_r | hit_b;
    a_sel     = a_found_r ? a_idx_r : dptr_r;
    b_sel     = b_found_r ? b_idx_r : dptr_r;
    last_step = (dptr_r == last_r);
    dptr_inc  = dptr_r + 1'b1;
  end

  // Next state, memory control and result.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    who_nxt        = who_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    dptr_nxt       = dptr_r;
    a_found_nxt    = a_found_r;
    a_idx_nxt      = a_idx_r;
    b_found_nxt    = b_found_r;
    b_idx_nxt      = b_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_region_nxt = out_region_r;
    cnt_we         = 1'b0;
    cnt_wdata      = '0;
    hold_we        = 1'b0;
    rd_addr        = dptr_inc;
    case (state_r)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        if (dptr_r == AW'(REGION_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          dptr_nxt = dptr_inc;
        end
      end
      ST_IDLE: begin
        rd_addr     = AW'(first_w);
        cmd_nxt     = in_command;
        who_nxt     = in_requester;
        first_nxt   = AW'(first_w);
        last_nxt    = AW'(last_w);
        a_found_nxt = 1'b0;
        b_found_nxt = 1'b0;
        if (start) begin
          dptr_nxt = AW'(first_w);
          if (len_zero) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_DONE;
            out_region_nxt = '0;
          end else if (out_of_range) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_RANGE;
            out_region_nxt = REGION_OUT_W'(bad_w);
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        a_found_nxt = a_any;
        a_idx_nxt   = a_sel;
        b_found_nxt = b_any;
        b_idx_nxt   = b_sel;
        if (last_step) begin
          rd_addr  = first_r;
          dptr_nxt = first_r;
          if (a_any) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = (cmd_r == CMD_ACQUIRE) ? STATUS_CONFLICT : STATUS_UNHELD;
            out_region_nxt = REGION_OUT_W'(a_sel);
            state_nxt      = ST_IDLE;
          end else if (b_any) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_OVERFLOW;
            out_region_nxt = REGION_OUT_W'(b_sel);
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end else begin
          dptr_nxt = dptr_inc;
        end
      end
      ST_UPDATE: begin
        cnt_we  = 1'b1;
        hold_we = (cmd_r == CMD_ACQUIRE);
        if (cmd_r == CMD_ACQUIRE) begin
          cnt_wdata = cnt_rdata + 1'b1;
        end else begin
          cnt_wdata = cnt_rdata - 1'b1;
        end
        if (last_step) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_DONE;
          out_region_nxt = '0;
          state_nxt      = ST_IDLE;
        end else begin
          dptr_nxt = dptr_inc;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      dptr_r      <= '0;
      out_valid_r <= 1'b0;
      regions_r   <= REGIONS_RESET;
    end else begin
      state_r     <= state_nxt;
      dptr_r      <= dptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        regions_r <= cfg_wdata;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    who_r        <= who_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    a_found_r    <= a_found_nxt;
    a_idx_r      <= a_idx_nxt;
    b_found_r    <= b_found_nxt;
    b_idx_r      <= b_idx_nxt;
    out_status_r <= out_status_nxt;
    out_region_r <= out_region_nxt;
  end

  // Hold count memory, cleared after reset.
  rlt_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (REGION_COUNT)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (dptr_r),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  // Holder memory, written on every acquire update.
  rlt_ram #(
    .WIDTH (REQ_W),
    .DEPTH (REGION_COUNT)
  ) u_holder_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (dptr_r),
    .wdata (who_r),
    .raddr (rd_addr),
    .rdata (hold_rdata)
  );

  // The walks stay inside the requested range.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_UPDATE) |-> (dptr_r >= first_r && dptr_r <= last_r))
    else $error("region walk left the requested range");

  // An acquire update never wraps a saturated count.
  a_no_wrap_up: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && cmd_r == CMD_ACQUIRE) |-> (cnt_rdata != HOLD_MAX))
    else $error("acquire update on a saturated count");

  // A release update never lowers a zero count.
  a_no_wrap_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && cmd_r == CMD_RELEASE) |-> (cnt_rdata != '0))
    else $error("release update on an unheld region");

  // A successful result reports region zero.
  a_done_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_DONE) |-> (out_conflict_region == '0))
    else $error("done result with a nonzero region");

  // An update walk is only entered when the check found nothing.
  a_update_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && state_nxt == ST_UPDATE) |-> (!a_any && !b_any))
    else $error("update started after a failed check");

endmodule
